[src/assert_macros.svh]
// Assertion helpers for the RTL, removed when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// a in a cycle implies b in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: a implies b");

// a in a cycle implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: a implies b next cycle");

`else

`define ASSERT_SAME(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

[src/mm4_pkg.sv]
package mm4_pkg;

  localparam int unsigned IDX_W     = 4;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned PROD_W    = 2 * VAL_W;
  localparam int unsigned FRAC_BITS = 16;

  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] left_value;
    logic signed [VAL_W-1:0] right_value;
    logic                    last_load;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]        product_index;
    logic signed [VAL_W-1:0] product_value;
    logic                    product_last;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // write the input beat into the stores
    logic issue;   // read one L/R pair for the current c, r, k
    logic first;   // k == 0: restart the accumulator
    logic last_k;  // k == D-1: sum complete after this term
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pipe_busy;
  } status_t;

endpackage

[src/mm4_ctrl.sv]
module mm4_ctrl #(
  parameter int unsigned MATRIX_DIM = 4,
  localparam int unsigned CW = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              last_load,
  input  mm4_pkg::status_t  status,
  output logic              busy,
  output mm4_pkg::cmd_t     cmd,
  output logic [CW-1:0]     col,
  output logic [CW-1:0]     row,
  output logic [CW-1:0]     kk
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_COMPUTE = 2'd1;
  localparam logic [1:0] ST_DRAIN   = 2'd2;

  localparam logic [CW-1:0] CNT_MAX = CW'(MATRIX_DIM - 1);

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          accept;
  logic          k_end, r_end, c_end;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign k_end  = (k_r == CNT_MAX);
  assign r_end  = (r_r == CNT_MAX);
  assign c_end  = (c_r == CNT_MAX);

  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && last_load) begin
          state_nxt = ST_COMPUTE;
          c_nxt     = '0;
          r_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_COMPUTE: begin
        if (k_end) begin
          k_nxt = '0;
          if (r_end) begin
            r_nxt = '0;
            if (c_end) begin
              c_nxt     = '0;
              state_nxt = ST_DRAIN;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end else begin
            r_nxt = r_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load   = accept;
    cmd.issue  = (state_r == ST_COMPUTE);
    cmd.first  = (k_r == '0);
    cmd.last_k = k_end;
  end

  assign col = c_r;
  assign row = r_r;
  assign kk  = k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      c_r     <= '0;
      r_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      c_r     <= c_nxt;
      r_r     <= r_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

[src/mm4_datapath.sv]
module mm4_datapath #(
  parameter int unsigned MATRIX_DIM = 4,
  localparam int unsigned CW    = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1,
  localparam int unsigned DEPTH = MATRIX_DIM * MATRIX_DIM,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mm4_pkg::cmd_t       cmd,
  input  logic [CW-1:0]       col,
  input  logic [CW-1:0]       row,
  input  logic [CW-1:0]       kk,
  input  mm4_pkg::in_beat_t   in_data,
  output mm4_pkg::status_t    status,
  output logic                out_valid,
  output mm4_pkg::out_beat_t  out_data
);

  localparam int unsigned VAL_W  = mm4_pkg::VAL_W;
  localparam int unsigned PROD_W = mm4_pkg::PROD_W;
  localparam int unsigned FRAC   = mm4_pkg::FRAC_BITS;
  // D products of at most 2^62 each
  localparam int unsigned ACC_W  = PROD_W + CW;
  // floor-shifted sum fits 32 bits when bits [ACC_W-1 : FRAC+VAL_W-1] all agree
  localparam int unsigned SAT_LO = FRAC + VAL_W - 1;

  logic [VAL_W-1:0] left_mem  [DEPTH];
  logic [VAL_W-1:0] right_mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] l_addr, r_addr, pos;

  // stage 1: store read
  logic                    s1_v_r, s1_first_r, s1_last_r;
  logic [AW-1:0]           s1_pos_r;
  logic signed [VAL_W-1:0] s1_l_r, s1_rv_r;
  // stage 2: product
  logic                     s2_v_r, s2_first_r, s2_last_r;
  logic [AW-1:0]            s2_pos_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  // stage 3: accumulate
  logic                    s3_v_r, s3_done_r;
  logic [AW-1:0]           s3_pos_r;
  logic signed [ACC_W-1:0] acc_r;
  // stage 4: result register
  logic                    out_valid_r;
  mm4_pkg::out_beat_t      out_data_r;

  logic [ACC_W-SAT_LO-1:0] acc_hi;
  logic                    in_range;
  logic signed [VAL_W-1:0] sat_value;

  assign wr_en   = cmd.load && (32'(in_data.element_index) < DEPTH);
  assign wr_addr = AW'(in_data.element_index);
  assign l_addr  = AW'(32'(kk) * MATRIX_DIM + 32'(row));
  assign r_addr  = AW'(32'(col) * MATRIX_DIM + 32'(kk));
  assign pos     = AW'(32'(col) * MATRIX_DIM + 32'(row));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= in_data.left_value;
      right_mem[wr_addr] <= in_data.right_value;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    s1_l_r     <= valid_r[l_addr] ? left_mem[l_addr] : '0;
    s1_rv_r    <= valid_r[r_addr] ? right_mem[r_addr] : '0;
    s1_first_r <= cmd.first;
    s1_last_r  <= cmd.last_k;
    s1_pos_r   <= pos;

    s2_prod_r  <= s1_l_r * s1_rv_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_pos_r   <= s1_pos_r;

    if (s2_v_r) begin
      if (s2_first_r) begin
        acc_r <= ACC_W'(s2_prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(s2_prod_r);
      end
    end
    s3_pos_r <= s2_pos_r;

    out_data_r.product_index <= mm4_pkg::IDX_W'(s3_pos_r);
    out_data_r.product_value <= sat_value;
    out_data_r.product_last  <= (32'(s3_pos_r) == DEPTH - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s3_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= cmd.issue;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s3_done_r   <= s2_v_r && s2_last_r;
      out_valid_r <= s3_done_r;
    end
  end

  // floor shift by FRAC, then clamp
  assign acc_hi   = acc_r[ACC_W-1:SAT_LO];
  assign in_range = (&acc_hi) || !(|acc_hi);

  always_comb begin
    if (in_range) begin
      sat_value = acc_r[SAT_LO:FRAC];
    end else if (acc_r[ACC_W-1]) begin
      sat_value = mm4_pkg::Q_MIN;
    end else begin
      sat_value = mm4_pkg::Q_MAX;
    end
  end

  assign status.pipe_busy = s1_v_r || s2_v_r || s3_v_r;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule

[src/matrix_multiply_4x4_core.sv]
// Column-major matrix product C = L * R, signed Q16.16, D = MATRIX_DIM.
// Input: a beat is taken on a clock edge with start high and busy low. It
// writes in_data.left_value and in_data.right_value at in_data.element_index
// (column*D + row); indexes past the store are dropped. Busy stays low
// after a load without last_load, so loads can go back to back.
// A beat with last_load set is stored, then busy rises and the block
// computes all D*D products in index order, one multiply-accumulate per
// cycle through a single 32x32 multiplier and a pipeline of store read,
// multiply, accumulate and shift/saturate. Busy falls after the final
// result is out; results leave in index order, one per D summed terms.
// Output: out_valid is high for one cycle per result with out_data; the
// receiver cannot stall, so results are never held back. out_data
// .product_last marks the final element.
// Reset: both stores read as zero and the block is idle. Stores keep their
// contents between products; later loads overwrite single elements.
module matrix_multiply_4x4_core #(
  parameter int unsigned MATRIX_DIM = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mm4_pkg::in_beat_t   in_data,
  output logic                out_valid,
  output mm4_pkg::out_beat_t  out_data
);

  localparam int unsigned CW = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;

  mm4_pkg::cmd_t    cmd;
  mm4_pkg::status_t status;
  logic [CW-1:0]    col, row, kk;

  mm4_ctrl #(
    .MATRIX_DIM(MATRIX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_load (in_data.last_load),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd),
    .col       (col),
    .row       (row),
    .kk        (kk)
  );

  mm4_datapath #(
    .MATRIX_DIM(MATRIX_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .col       (col),
    .row       (row),
    .kk        (kk),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`include "assert_macros.svh"

  `ASSERT_SAME(a_result_while_busy, clk, rst_n, out_valid, busy)
  `ASSERT_NEXT(a_last_load_goes_busy, clk, rst_n, start && !busy && in_data.last_load, busy)
  `ASSERT_NEXT(a_nothing_after_final, clk, rst_n, out_valid && out_data.product_last, !out_valid)

endmodule
